// File: design/lpc_pkg.sv
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types, constants and helper functions for the lidar point converter.
// ----------------------------------------------------------------------------
package lpc_pkg;

  // Request kind carried in the input tuser bit
  typedef enum logic {
    REQ_LOAD    = 1'b0,
    REQ_CONVERT = 1'b1
  } req_t;

  // Widest angle and range the design supports
  localparam int ANGLE_MAX_BITS = 24;
  localparam int RANGE_MAX_BITS = 24;

  // Q2.30 fixed point
  localparam logic [31:0] ONE_Q30     = 32'd1073741824;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // Output coordinate saturation limit
  localparam logic [20:0] COORD_MAX = 21'd1048575;

  // Taylor series: next-term steps and trig unit latency in cycles
  localparam int TRIG_STEPS = 7;
  localparam int TRIG_LAT   = 3 * TRIG_STEPS + 4;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // Sine and cosine output of the trig unit, sign and magnitude form
  typedef struct packed {
    logic        s_neg;
    logic [30:0] s_mag;
    logic        c_neg;
    logic [30:0] c_mag;
  } trig_out_t;

  // Divisor that turns sine term k into term k+1
  function automatic int sin_div(input int k);
    return (2 * k + 2) * (2 * k + 3);
  endfunction

  // Divisor that turns cosine term k into term k+1
  function automatic int cos_div(input int k);
    return (2 * k + 1) * (2 * k + 2);
  endfunction

endpackage

// File: design/lpc_ram.sv
// ----------------------------------------------------------------------------
// lpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/lpc_trig.sv
// ----------------------------------------------------------------------------
// lpc_trig
// Pipelined sine/cosine of a binary angle, Q2.30, by a truncated Taylor series.
// ----------------------------------------------------------------------------
module lpc_trig #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [ANGLE_BITS-1:0]   angle,
  output lpc_pkg::trig_out_t      result
);
  import lpc_pkg::*;

  localparam int SHIFT = 32 - ANGLE_BITS;

  function automatic logic [30:0] clamp_unit(input logic signed [33:0] v);
    logic [30:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({2'b00, ONE_Q30})) begin
      r = ONE_Q30[30:0];
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction

  // Quadrant and fraction of a quarter turn
  logic [31:0] p;
  logic [29:0] frac;
  logic [60:0] x_prod;

  assign p      = 32'(angle) << SHIFT;
  assign frac   = p[29:0];
  assign x_prod = 61'(frac) * 61'(HALF_PI_Q30);

  // Stage a: fraction to radians
  logic [30:0] a_x;
  logic [1:0]  a_quad;

  always_ff @(posedge clk) begin
    if (en) begin
      a_x    <= x_prod[60:30];
      a_quad <= p[31:30];
    end
  end

  // Stage b: x squared
  logic [61:0] x_sq;
  logic [31:0] b_x2;
  logic [30:0] b_x;
  logic [1:0]  b_quad;

  assign x_sq = 62'(a_x) * 62'(a_x);

  always_ff @(posedge clk) begin
    if (en) begin
      b_x2   <= x_sq[61:30];
      b_x    <= a_x;
      b_quad <= a_quad;
    end
  end

  // Chain between series steps
  wire [31:0]        ts_w   [0:TRIG_STEPS];
  wire [31:0]        tc_w   [0:TRIG_STEPS];
  wire signed [33:0] accs_w [0:TRIG_STEPS];
  wire signed [33:0] accc_w [0:TRIG_STEPS];
  wire [31:0]        x2_w   [0:TRIG_STEPS];
  wire [1:0]         quad_w [0:TRIG_STEPS];

  assign ts_w[0]   = {1'b0, b_x};
  assign tc_w[0]   = ONE_Q30;
  assign accs_w[0] = '0;
  assign accc_w[0] = '0;
  assign x2_w[0]   = b_x2;
  assign quad_w[0] = b_quad;

  // Each step: add or subtract current term, multiply by x^2, divide by a constant
  for (genvar j = 0; j < TRIG_STEPS; j++) begin : g_step
    localparam int          DS    = sin_div(j);
    localparam int          DC    = cos_div(j);
    localparam logic [63:0] RS64  = 64'h1_0000_0000 / 64'(DS);
    localparam logic [63:0] RC64  = 64'h1_0000_0000 / 64'(DC);
    localparam logic [31:0] RS    = RS64[31:0];
    localparam logic [31:0] RC    = RC64[31:0];
    localparam logic [31:0] DS32  = 32'(DS);
    localparam logic [31:0] DC32  = 32'(DC);

    logic [63:0]        prod_s, prod_c;
    logic signed [33:0] term_s, term_c;
    logic signed [33:0] accs_nx, accc_nx;

    // mul stage
    logic [31:0]        m_ps, m_pc, m_x2;
    logic signed [33:0] m_accs, m_accc;
    logic [1:0]         m_quad;

    assign prod_s = 64'(ts_w[j]) * 64'(x2_w[j]);
    assign prod_c = 64'(tc_w[j]) * 64'(x2_w[j]);
    assign term_s = $signed({2'b00, ts_w[j]});
    assign term_c = $signed({2'b00, tc_w[j]});

    if (j % 2 == 0) begin : g_add
      assign accs_nx = accs_w[j] + term_s;
      assign accc_nx = accc_w[j] + term_c;
    end else begin : g_sub
      assign accs_nx = accs_w[j] - term_s;
      assign accc_nx = accc_w[j] - term_c;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_ps   <= prod_s[61:30];
        m_pc   <= prod_c[61:30];
        m_accs <= accs_nx;
        m_accc <= accc_nx;
        m_x2   <= x2_w[j];
        m_quad <= quad_w[j];
      end
    end

    // reciprocal stage: quotient estimate, low by at most one
    logic [63:0]        rq_s, rq_c;
    logic [31:0]        r_qs, r_qc, r_ps, r_pc, r_x2;
    logic signed [33:0] r_accs, r_accc;
    logic [1:0]         r_quad;

    assign rq_s = 64'(m_ps) * 64'(RS);
    assign rq_c = 64'(m_pc) * 64'(RC);

    always_ff @(posedge clk) begin
      if (en) begin
        r_qs   <= rq_s[63:32];
        r_qc   <= rq_c[63:32];
        r_ps   <= m_ps;
        r_pc   <= m_pc;
        r_accs <= m_accs;
        r_accc <= m_accc;
        r_x2   <= m_x2;
        r_quad <= m_quad;
      end
    end

    // correction stage: bump quotient when remainder reaches divisor
    logic [31:0]        qd_s, qd_c, rem_s, rem_c;
    logic [31:0]        c_ts, c_tc, c_x2;
    logic signed [33:0] c_accs, c_accc;
    logic [1:0]         c_quad;

    assign qd_s  = r_qs * DS32;
    assign qd_c  = r_qc * DC32;
    assign rem_s = r_ps - qd_s;
    assign rem_c = r_pc - qd_c;

    always_ff @(posedge clk) begin
      if (en) begin
        c_ts   <= r_qs + 32'(rem_s >= DS32);
        c_tc   <= r_qc + 32'(rem_c >= DC32);
        c_accs <= r_accs;
        c_accc <= r_accc;
        c_x2   <= r_x2;
        c_quad <= r_quad;
      end
    end

    assign ts_w[j+1]   = c_ts;
    assign tc_w[j+1]   = c_tc;
    assign accs_w[j+1] = c_accs;
    assign accc_w[j+1] = c_accc;
    assign x2_w[j+1]   = c_x2;
    assign quad_w[j+1] = c_quad;
  end

  // Final sum: the last term has odd index, so it is subtracted
  logic signed [33:0] f_s, f_c;
  logic [1:0]         f_quad;

  always_ff @(posedge clk) begin
    if (en) begin
      f_s    <= accs_w[TRIG_STEPS] - $signed({2'b00, ts_w[TRIG_STEPS]});
      f_c    <= accc_w[TRIG_STEPS] - $signed({2'b00, tc_w[TRIG_STEPS]});
      f_quad <= quad_w[TRIG_STEPS];
    end
  end

  // Clamp to [0, 1] and apply quadrant
  logic [30:0] s_cl, c_cl;
  trig_out_t   res_nx;

  assign s_cl = clamp_unit(f_s);
  assign c_cl = clamp_unit(f_c);

  always_comb begin
    unique case (f_quad)
      2'd0: res_nx = '{s_neg: 1'b0, s_mag: s_cl, c_neg: 1'b0, c_mag: c_cl};
      2'd1: res_nx = '{s_neg: 1'b0, s_mag: c_cl, c_neg: 1'b1, c_mag: s_cl};
      2'd2: res_nx = '{s_neg: 1'b1, s_mag: s_cl, c_neg: 1'b1, c_mag: c_cl};
      default: res_nx = '{s_neg: 1'b1, s_mag: c_cl, c_neg: 1'b0, c_mag: s_cl};
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= res_nx;
    end
  end

endmodule

// File: design/lpc_front.sv
// ----------------------------------------------------------------------------
// lpc_front
// Accepts items, keeps the beam calibration table, queues convert work.
// ----------------------------------------------------------------------------
module lpc_front #(
  parameter int BEAM_COUNT = 64,
  parameter int ANGLE_BITS = 16,
  parameter int RANGE_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  // input item
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lpc_pkg::req_t         req,
  input  logic [5:0]            beam_index,
  input  logic [15:0]           azimuth_offset,
  input  logic [15:0]           altitude_angle,
  input  logic [15:0]           shot_azimuth,
  input  logic [19:0]           range_mm,
  input  logic [7:0]            return_intensity,
  input  logic                  scan_end,
  // queue head toward the back end
  output logic                  q_valid,
  input  logic                  q_pop,
  output logic [ANGLE_BITS-1:0] q_h,
  output logic [ANGLE_BITS-1:0] q_alt,
  output logic [RANGE_BITS-1:0] q_range,
  output logic [7:0]            q_intensity,
  output logic                  q_last
);
  import lpc_pkg::*;

  localparam int         AW         = (BEAM_COUNT > 1) ? $clog2(BEAM_COUNT) : 1;
  localparam logic [8:0] BEAM_LIMIT = 9'(BEAM_COUNT);

  // Field extension to the maximum supported widths
  logic [ANGLE_MAX_BITS-1:0] off_ext, alt_ext, shot_ext;
  logic [RANGE_MAX_BITS-1:0] range_ext;
  logic [7:0]                beam8;
  logic [AW-1:0]             addr;
  logic                      beam_ok;
  logic                      accept;
  logic                      load_we;
  logic                      conv_acc;

  assign off_ext   = ANGLE_MAX_BITS'(azimuth_offset);
  assign alt_ext   = ANGLE_MAX_BITS'(altitude_angle);
  assign shot_ext  = ANGLE_MAX_BITS'(shot_azimuth);
  assign range_ext = RANGE_MAX_BITS'(range_mm);
  assign beam8     = 8'(beam_index);
  assign addr      = beam8[AW-1:0];
  assign beam_ok   = 9'(beam_index) < BEAM_LIMIT;

  assign accept   = in_valid && in_ready;
  assign load_we  = accept && (req == REQ_LOAD) && beam_ok;
  assign conv_acc = accept && (req == REQ_CONVERT);

  // Calibration table: {altitude, azimuth offset} per beam
  logic [2*ANGLE_BITS-1:0] cal_rdata;

  lpc_ram #(
    .WIDTH (2 * ANGLE_BITS),
    .DEPTH (BEAM_COUNT)
  ) u_cal_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (addr),
    .wdata ({alt_ext[ANGLE_BITS-1:0], off_ext[ANGLE_BITS-1:0]}),
    .re    (conv_acc),
    .raddr (addr),
    .rdata (cal_rdata)
  );

  // Lookup stage, aligned with the registered table read
  logic                  st1_valid;
  logic                  st1_ok;
  logic [ANGLE_BITS-1:0] st1_shot;
  logic [RANGE_BITS-1:0] st1_range;
  logic [7:0]            st1_int;
  logic                  st1_last;
  logic                  st1_move;
  logic                  q_full;

  assign st1_move = st1_valid && !q_full;
  assign in_ready = !st1_valid || !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
    end else if (conv_acc) begin
      st1_valid <= 1'b1;
    end else if (st1_move) begin
      st1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (conv_acc) begin
      st1_ok    <= beam_ok;
      st1_shot  <= shot_ext[ANGLE_BITS-1:0];
      st1_range <= range_ext[RANGE_BITS-1:0];
      st1_int   <= return_intensity;
      st1_last  <= scan_end;
    end
  end

  // Azimuth sum wraps as a binary angle; unknown beam reads as zero
  logic [ANGLE_BITS-1:0] cal_off, cal_alt, push_h;

  assign cal_off = st1_ok ? cal_rdata[ANGLE_BITS-1:0] : '0;
  assign cal_alt = st1_ok ? cal_rdata[2*ANGLE_BITS-1:ANGLE_BITS] : '0;
  assign push_h  = st1_shot + cal_off;

  // Work queue
  logic [ANGLE_BITS-1:0] qh_mem   [QDEPTH];
  logic [ANGLE_BITS-1:0] qa_mem   [QDEPTH];
  logic [RANGE_BITS-1:0] qr_mem   [QDEPTH];
  logic [7:0]            qi_mem   [QDEPTH];
  logic                  ql_mem   [QDEPTH];
  logic [QAW-1:0]        wr_ptr, rd_ptr;
  logic [QAW:0]          count;
  logic                  do_pop;

  assign q_full  = count == (QAW + 1)'(QDEPTH);
  assign q_valid = count != '0;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (st1_move) begin
      qh_mem[wr_ptr] <= push_h;
      qa_mem[wr_ptr] <= cal_alt;
      qr_mem[wr_ptr] <= st1_range;
      qi_mem[wr_ptr] <= st1_int;
      ql_mem[wr_ptr] <= st1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (st1_move) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (st1_move && !do_pop) begin
        count <= count + 1'b1;
      end else if (!st1_move && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  assign q_h         = qh_mem[rd_ptr];
  assign q_alt       = qa_mem[rd_ptr];
  assign q_range     = qr_mem[rd_ptr];
  assign q_intensity = qi_mem[rd_ptr];
  assign q_last      = ql_mem[rd_ptr];

endmodule

// File: design/lpc_back.sv
// ----------------------------------------------------------------------------
// lpc_back
// Trig pipelines and range scaling; produces one Cartesian point per word.
// ----------------------------------------------------------------------------
module lpc_back #(
  parameter int ANGLE_BITS = 16,
  parameter int RANGE_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  // queue head
  input  logic                  q_valid,
  output logic                  q_pop,
  input  logic [ANGLE_BITS-1:0] q_h,
  input  logic [ANGLE_BITS-1:0] q_alt,
  input  logic [RANGE_BITS-1:0] q_range,
  input  logic [7:0]            q_intensity,
  input  logic                  q_last,
  // point output
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [20:0]           pos_x,
  output logic [20:0]           pos_y,
  output logic [20:0]           pos_z,
  output logic [7:0]            point_intensity,
  output logic                  last_point
);
  import lpc_pkg::*;

  localparam int PW = RANGE_BITS + 31;

  // Saturate magnitude and apply sign, 21-bit two's complement
  function automatic logic [20:0] sat_sign(input logic [RANGE_BITS-1:0] mag,
                                           input logic neg);
    logic [RANGE_MAX_BITS:0] ext;
    logic [20:0]             v;
    ext = (RANGE_MAX_BITS + 1)'(mag);
    if (ext > (RANGE_MAX_BITS + 1)'(COORD_MAX)) begin
      v = COORD_MAX;
    end else begin
      v = ext[20:0];
    end
    return neg ? -v : v;
  endfunction

  // Round half up of a Q30 product
  function automatic logic [RANGE_BITS-1:0] round_q30(input logic [PW-1:0] prod);
    logic [PW:0] sum;
    sum = (PW + 1)'(prod) + ((PW + 1)'(1) << 29);
    return sum[RANGE_BITS+29:30];
  endfunction

  // Whole pipeline advances together when the output can move
  logic en;

  assign en    = !out_valid || out_ready;
  assign q_pop = en && q_valid;

  // Trig units for altitude and azimuth
  trig_out_t trig_v, trig_h;

  lpc_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_v (
    .clk    (clk),
    .en     (en),
    .angle  (q_alt),
    .result (trig_v)
  );

  lpc_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_h (
    .clk    (clk),
    .en     (en),
    .angle  (q_h),
    .result (trig_h)
  );

  // Side line matching trig latency
  logic                  sd_valid [TRIG_LAT];
  logic [RANGE_BITS-1:0] sd_range [TRIG_LAT];
  logic [7:0]            sd_int   [TRIG_LAT];
  logic                  sd_last  [TRIG_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TRIG_LAT; i++) begin
        sd_valid[i] <= 1'b0;
      end
    end else if (en) begin
      sd_valid[0] <= q_valid;
      for (int i = 1; i < TRIG_LAT; i++) begin
        sd_valid[i] <= sd_valid[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_range[0] <= q_range;
      sd_int[0]   <= q_intensity;
      sd_last[0]  <= q_last;
      for (int i = 1; i < TRIG_LAT; i++) begin
        sd_range[i] <= sd_range[i-1];
        sd_int[i]   <= sd_int[i-1];
        sd_last[i]  <= sd_last[i-1];
      end
    end
  end

  // Valid bits of the scaling stages
  logic b1_valid, b2_valid, b3_valid, b4_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      b3_valid  <= 1'b0;
      b4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      b1_valid  <= sd_valid[TRIG_LAT-1];
      b2_valid  <= b1_valid;
      b3_valid  <= b2_valid;
      b4_valid  <= b3_valid;
      out_valid <= b4_valid;
    end
  end

  // B1: r * |cos v| and r * |sin v|
  logic [PW-1:0] b1_pc, b1_ps;
  logic [30:0]   b1_ch, b1_sh;
  logic          b1_cvn, b1_svn, b1_chn, b1_shn, b1_last;
  logic [7:0]    b1_int;

  always_ff @(posedge clk) begin
    if (en) begin
      b1_pc   <= PW'(sd_range[TRIG_LAT-1]) * PW'(trig_v.c_mag);
      b1_ps   <= PW'(sd_range[TRIG_LAT-1]) * PW'(trig_v.s_mag);
      b1_ch   <= trig_h.c_mag;
      b1_sh   <= trig_h.s_mag;
      b1_cvn  <= trig_v.c_neg;
      b1_svn  <= trig_v.s_neg;
      b1_chn  <= trig_h.c_neg;
      b1_shn  <= trig_h.s_neg;
      b1_int  <= sd_int[TRIG_LAT-1];
      b1_last <= sd_last[TRIG_LAT-1];
    end
  end

  // B2: round to mm; horizontal radius and z magnitude
  logic [RANGE_BITS-1:0] b2_rc, b2_z;
  logic [30:0]           b2_ch, b2_sh;
  logic                  b2_xn, b2_yn, b2_zn, b2_last;
  logic [7:0]            b2_int;

  always_ff @(posedge clk) begin
    if (en) begin
      b2_rc   <= round_q30(b1_pc);
      b2_z    <= round_q30(b1_ps);
      b2_ch   <= b1_ch;
      b2_sh   <= b1_sh;
      b2_xn   <= b1_cvn ^ b1_chn;
      b2_yn   <= !(b1_cvn ^ b1_shn);
      b2_zn   <= b1_svn;
      b2_int  <= b1_int;
      b2_last <= b1_last;
    end
  end

  // B3: horizontal radius times |cos h| and |sin h|
  logic [PW-1:0]         b3_px, b3_py;
  logic [RANGE_BITS-1:0] b3_z;
  logic                  b3_xn, b3_yn, b3_zn, b3_last;
  logic [7:0]            b3_int;

  always_ff @(posedge clk) begin
    if (en) begin
      b3_px   <= PW'(b2_rc) * PW'(b2_ch);
      b3_py   <= PW'(b2_rc) * PW'(b2_sh);
      b3_z    <= b2_z;
      b3_xn   <= b2_xn;
      b3_yn   <= b2_yn;
      b3_zn   <= b2_zn;
      b3_int  <= b2_int;
      b3_last <= b2_last;
    end
  end

  // B4: round x and y
  logic [RANGE_BITS-1:0] b4_x, b4_y, b4_z;
  logic                  b4_xn, b4_yn, b4_zn, b4_last;
  logic [7:0]            b4_int;

  always_ff @(posedge clk) begin
    if (en) begin
      b4_x    <= round_q30(b3_px);
      b4_y    <= round_q30(b3_py);
      b4_z    <= b3_z;
      b4_xn   <= b3_xn;
      b4_yn   <= b3_yn;
      b4_zn   <= b3_zn;
      b4_int  <= b3_int;
      b4_last <= b3_last;
    end
  end

  // Output register: saturate and sign
  always_ff @(posedge clk) begin
    if (en) begin
      pos_x           <= sat_sign(b4_x, b4_xn);
      pos_y           <= sat_sign(b4_y, b4_yn);
      pos_z           <= sat_sign(b4_z, b4_zn);
      point_intensity <= b4_int;
      last_point      <= b4_last;
    end
  end

endmodule

// File: design/lidar_polar_to_cartesian.sv
// ----------------------------------------------------------------------------
// lidar_polar_to_cartesian
// Converts lidar returns to Cartesian points using per-beam calibration angles.
// ----------------------------------------------------------------------------
// A load word (tuser = 0) writes one beam's azimuth offset and altitude into
// the calibration table and gives no output. A convert word (tuser = 1) adds
// the beam offset to the shot azimuth and emits x = r cos v cos h,
// y = -r cos v sin h, z = r sin v in millimetres, saturated to +-1048575,
// with intensity and tlast copied through. The block takes one word per
// cycle and emits one point per cycle while m_tready stays high. The
// sine/cosine pipeline runs seven Taylor series steps of multiply,
// reciprocal multiply and correction, three stages each, and is followed
// by two multiply-and-round passes for the range. A four-word queue sits
// between the table lookup and the arithmetic pipeline, so input keeps
// flowing while a point waits on the output, until the queue fills.
// Converting a beam that was never loaded gives an undefined point.
// ----------------------------------------------------------------------------
module lidar_polar_to_cartesian #(
  parameter int BEAM_COUNT = 64,
  parameter int ANGLE_BITS = 16,
  parameter int RANGE_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // [5:0] beam_index, [21:6] azimuth_offset, [37:22] altitude_angle,
  // [53:38] shot_azimuth, [73:54] range_mm, [81:74] return_intensity,
  // [87:82] zero
  input  logic [87:0] s_tdata,
  // [0] req_type
  input  logic        s_tuser,
  input  logic        s_tlast,
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [20:0] pos_x, [41:21] pos_y, [62:42] pos_z, [70:63] point_intensity,
  // [71] zero
  output logic [71:0] m_tdata,
  output logic        m_tlast
);
  import lpc_pkg::*;

  // Front to back queue
  logic                  q_valid, q_pop, q_last;
  logic [ANGLE_BITS-1:0] q_h, q_alt;
  logic [RANGE_BITS-1:0] q_range;
  logic [7:0]            q_intensity;
  logic                  in_ready;

  lpc_front #(
    .BEAM_COUNT (BEAM_COUNT),
    .ANGLE_BITS (ANGLE_BITS),
    .RANGE_BITS (RANGE_BITS)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (s_tvalid),
    .in_ready         (in_ready),
    .req              (req_t'(s_tuser)),
    .beam_index       (s_tdata[5:0]),
    .azimuth_offset   (s_tdata[21:6]),
    .altitude_angle   (s_tdata[37:22]),
    .shot_azimuth     (s_tdata[53:38]),
    .range_mm         (s_tdata[73:54]),
    .return_intensity (s_tdata[81:74]),
    .scan_end         (s_tlast),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_h              (q_h),
    .q_alt            (q_alt),
    .q_range          (q_range),
    .q_intensity      (q_intensity),
    .q_last           (q_last)
  );

  assign s_tready = in_ready;

  // Arithmetic back end
  logic [20:0] pos_x, pos_y, pos_z;
  logic [7:0]  point_intensity;

  lpc_back #(
    .ANGLE_BITS (ANGLE_BITS),
    .RANGE_BITS (RANGE_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_h             (q_h),
    .q_alt           (q_alt),
    .q_range         (q_range),
    .q_intensity     (q_intensity),
    .q_last          (q_last),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .pos_z           (pos_z),
    .point_intensity (point_intensity),
    .last_point      (m_tlast)
  );

  assign m_tdata = {1'b0, point_intensity, pos_z, pos_y, pos_x};

endmodule
